// ----- rtl/direct_mapped_pair_key_table_defines.svh -----
// Assertion macros shared by the pair key table modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef DIRECT_MAPPED_PAIR_KEY_TABLE_DEFINES_SVH
`define DIRECT_MAPPED_PAIR_KEY_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMPK_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmpk: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DMPK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmpk: next-cycle check failed");

`endif

// ----- rtl/dmpk_pkg.sv -----
`timescale 1ns / 1ps

package dmpk_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_KEY_WIDTH   = 16;

    localparam int VALUE_W    = 31;
    localparam int SIZE_W     = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET      = 5'd15;
    localparam logic [APB_AW-1:0] ADDR_TABLE_SIZE = 3'd0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_DELETE = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OCCUPIED  = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_ADD,
        ST_MOD,
        ST_READ,
        ST_CHECK
    } state_t;

endpackage

// ----- rtl/dmpk_divstep.sv -----
`timescale 1ns / 1ps

module dmpk_divstep (
    input  logic [dmpk_pkg::SIZE_W-1:0] rem_in,
    input  logic                        bit_in,
    input  logic [dmpk_pkg::SIZE_W-1:0] divisor,
    output logic [dmpk_pkg::SIZE_W-1:0] rem_out
);
    import dmpk_pkg::*;

    logic [SIZE_W:0] shifted;

    // One restoring step: bring in the next dividend bit, subtract once if it fits.
    always_comb
    begin
        shifted = {rem_in, bit_in};
        if (shifted >= {1'b0, divisor})
        begin
            rem_out = SIZE_W'(shifted - {1'b0, divisor});
        end
        else
        begin
            rem_out = SIZE_W'(shifted);
        end
    end

endmodule

// ----- rtl/dmpk_mem.sv -----
`timescale 1ns / 1ps

module dmpk_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/dmpk_seq.sv -----
`timescale 1ns / 1ps
`include "direct_mapped_pair_key_table_defines.svh"

module dmpk_seq #(
    parameter int TABLE_DEPTH = dmpk_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = dmpk_pkg::DEF_KEY_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dmpk_pkg::ACTION_W-1:0]   action,
    input  logic [KEY_WIDTH-1:0]            key_m,
    input  logic [KEY_WIDTH-1:0]            key_n,
    input  logic [dmpk_pkg::VALUE_W-1:0]    new_value,
    input  logic [dmpk_pkg::SIZE_W-1:0]     table_size,
    input  logic                            out_free,
    output logic                            res_valid,
    output logic [dmpk_pkg::STATUS_W-1:0]   status,
    output logic [dmpk_pkg::SLOT_OUT_W-1:0] slot_index,
    output logic [KEY_WIDTH-1:0]            found_m,
    output logic [KEY_WIDTH-1:0]            found_n,
    output logic [dmpk_pkg::VALUE_W-1:0]    found_value
);
    import dmpk_pkg::*;

    localparam int SUM_W  = KEY_WIDTH + 1;
    localparam int CODE_W = 2 * KEY_WIDTH + 2;
    localparam int CNT_W  = $clog2(CODE_W);
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int EW     = 1 + 2 * KEY_WIDTH + VALUE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(CODE_W - 1);

    state_t state_reg, state_next;

    logic [ACTION_W-1:0]  action_reg;
    logic [KEY_WIDTH-1:0] m_reg;
    logic [KEY_WIDTH-1:0] n_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [SIZE_W-1:0]    rem_reg;
    logic [SIZE_W-1:0]    rem_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     clr_reg;

    logic [SIZE_W-1:0]    divisor;
    logic [SUM_W-1:0]     sum_inc;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [IDX_W-1:0]     mem_raddr;
    logic [EW-1:0]        mem_wdata;
    logic [EW-1:0]        mem_rdata;

    logic                 rd_valid;
    logic [KEY_WIDTH-1:0] rd_m;
    logic [KEY_WIDTH-1:0] rd_n;
    logic [VALUE_W-1:0]   rd_v;
    logic                 hit;

    // Effective modulus: zero counts as one, anything past the table as its depth.
    always_comb
    begin
        divisor = table_size;
        if (table_size == '0)
        begin
            divisor = SIZE_W'(1);
        end
        else if (32'(table_size) > 32'(TABLE_DEPTH))
        begin
            divisor = SIZE_W'(TABLE_DEPTH);
        end
    end

    assign sum_inc = sum_reg + SUM_W'(1);

    dmpk_divstep u_divstep (
        .rem_in  (rem_reg),
        .bit_in  (code_reg[CODE_W-1]),
        .divisor (divisor),
        .rem_out (rem_next)
    );

    assign mem_raddr = IDX_W'(rem_reg);

    dmpk_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_valid = mem_rdata[EW-1];
    assign rd_m     = mem_rdata[EW-2 -: KEY_WIDTH];
    assign rd_n     = mem_rdata[VALUE_W +: KEY_WIDTH];
    assign rd_v     = mem_rdata[VALUE_W-1:0];
    assign hit      = rd_valid && (rd_m == m_reg) && (rd_n == n_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_MOD;
            ST_MOD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs and table update.
    always_comb
    begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = IDX_W'(rem_reg);
        mem_wdata   = '0;
        status      = STAT_NOT_FOUND;
        found_m     = '0;
        found_n     = '0;
        found_value = '0;
        slot_index  = SLOT_OUT_W'(rem_reg);
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CHECK:
            begin
                res_valid = out_free;
                case (action_reg) inside
                    ACT_INSERT:
                    begin
                        status    = rd_valid ? STAT_OCCUPIED : STAT_OK;
                        mem_we    = out_free && !rd_valid;
                        mem_wdata = {1'b1, m_reg, n_reg, val_reg};
                    end
                    ACT_LOOKUP, ACT_DELETE:
                    begin
                        if (hit)
                        begin
                            status      = STAT_OK;
                            found_m     = rd_m;
                            found_n     = rd_n;
                            found_value = rd_v;
                            mem_we      = out_free && (action_reg == ACT_DELETE);
                            mem_wdata   = {1'b0, rd_m, rd_n, rd_v};
                        end
                    end
                    default:
                    begin
                        status = STAT_NOT_FOUND;
                    end
                endcase
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        code_next = code_reg;
        unique case (state_reg)
            ST_MUL:  code_next = CODE_W'(sum_reg) * CODE_W'(sum_inc);
            ST_ADD:  code_next = (code_reg >> 1) + CODE_W'(n_reg);
            ST_MOD:  code_next = code_reg << 1;
            default: code_next = code_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (state_reg == ST_ADD)
            begin
                cnt_reg <= LAST_BIT;
            end
            else if (state_reg == ST_MOD)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            action_reg <= action;
            m_reg      <= key_m;
            n_reg      <= key_n;
            val_reg    <= new_value;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= SUM_W'(m_reg) + SUM_W'(n_reg);
        end
        if (state_reg == ST_ADD)
        begin
            rem_reg <= '0;
        end
        else if (state_reg == ST_MOD)
        begin
            rem_reg <= rem_next;
        end
    end

    `DMPK_ASSERT_SAME(a_rem_below_divisor, state_reg == ST_MOD, rem_reg < divisor)
    `DMPK_ASSERT_SAME(a_clear_writes_empty, state_reg == ST_CLEAR, mem_we && !mem_wdata[EW-1])
    `DMPK_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `DMPK_ASSERT_SAME(a_update_with_result, mem_we && state_reg == ST_CHECK, res_valid)

endmodule

// ----- rtl/direct_mapped_pair_key_table.sv -----
`timescale 1ns / 1ps
`include "direct_mapped_pair_key_table_defines.svh"

// Direct-mapped key/value table keyed by a pair (m, n), one entry per slot and no chaining.
// A word on the slave stream asks for an insert, lookup or delete (s_tuser) of a key pair,
// with a value for insert; each word gives exactly one result word on the master stream.
// The slot is the Cantor pairing value s*(s+1)/2 + n, with s = m + n, taken modulo the
// table_size register (0 acts as 1, sizes past TABLE_DEPTH act as TABLE_DEPTH). The pairing
// value is built in the sum, multiply and add states, with a single multiply, and then reduced
// by a single shared restoring divide step, one bit per cycle; a table read and compare follow,
// and the sequencer then returns to idle, where it takes the next word. s_tready is low from
// acceptance until then, also while the result waits in the compare state for the output
// register to drain. The result sits in an output register, so the next word is taken
// while a result waits on m_tready. After reset the block walks the table once to clear
// it and accepts no word meanwhile; configuration writes are taken at any time but belong
// in idle periods.
module direct_mapped_pair_key_table #(
    parameter int TABLE_DEPTH = dmpk_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = dmpk_pkg::DEF_KEY_WIDTH
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    // APB configuration port
    input  logic                                                   psel,
    input  logic                                                   penable,
    input  logic                                                   pwrite,
    input  logic [dmpk_pkg::APB_AW-1:0]                            paddr,
    input  logic [dmpk_pkg::APB_DW-1:0]                            pwdata,
    output logic [dmpk_pkg::APB_DW-1:0]                            prdata,
    output logic                                                   pready,
    // Request stream
    input  logic                                                   s_tvalid,
    output logic                                                   s_tready,
    // s_tdata, low bit up: key_m, key_n, new_value, zero fill
    input  logic [((2*KEY_WIDTH+dmpk_pkg::VALUE_W+7)/8)*8-1:0]     s_tdata,
    // s_tuser: action
    input  logic [dmpk_pkg::ACTION_W-1:0]                          s_tuser,
    // Result stream
    output logic                                                   m_tvalid,
    input  logic                                                   m_tready,
    // m_tdata, low bit up: slot_index, found_m, found_n, found_value, zero fill
    output logic [((2*KEY_WIDTH+dmpk_pkg::VALUE_W+dmpk_pkg::SLOT_OUT_W+7)/8)*8-1:0] m_tdata,
    // m_tuser: status
    output logic [dmpk_pkg::STATUS_W-1:0]                          m_tuser
);
    import dmpk_pkg::*;

    localparam int OUT_W    = SLOT_OUT_W + 2 * KEY_WIDTH + VALUE_W;
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

    logic [SIZE_W-1:0] size_reg;
    logic              cfg_write;

    logic              out_free;
    logic              res_valid;
    logic [STATUS_W-1:0]   res_status;
    logic [SLOT_OUT_W-1:0] res_slot;
    logic [KEY_WIDTH-1:0]  res_m;
    logic [KEY_WIDTH-1:0]  res_n;
    logic [VALUE_W-1:0]    res_v;

    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_data_reg;
    logic [STATUS_W-1:0] m_status_reg;

    // The only register is table_size at byte address zero; other addresses read zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_TABLE_SIZE);
    assign prdata    = (paddr == ADDR_TABLE_SIZE) ? APB_DW'(size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // The sequencer hands over a result only when the output register is free or draining.
    assign out_free = !m_valid_reg || m_tready;

    dmpk_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .action      (s_tuser),
        .key_m       (s_tdata[KEY_WIDTH-1:0]),
        .key_n       (s_tdata[2*KEY_WIDTH-1:KEY_WIDTH]),
        .new_value   (s_tdata[2*KEY_WIDTH+VALUE_W-1:2*KEY_WIDTH]),
        .table_size  (size_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .status      (res_status),
        .slot_index  (res_slot),
        .found_m     (res_m),
        .found_n     (res_n),
        .found_value (res_v)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_data_reg   <= {res_v, res_n, res_m, res_slot};
            m_status_reg <= res_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TD_W'(m_data_reg);
    assign m_tuser  = m_status_reg;

    `DMPK_ASSERT_NEXT(a_result_lands, res_valid, m_tvalid)
    `DMPK_ASSERT_SAME(a_no_overwrite, res_valid, !m_valid_reg || m_tready)
    `DMPK_ASSERT_NEXT(a_cfg_takes_value, cfg_write, size_reg == $past(pwdata[SIZE_W-1:0]))

endmodule

// ----- bench/tb_direct_mapped_pair_key_table.sv -----
`timescale 1ns / 1ps

module tb_direct_mapped_pair_key_table;
    import dmpk_pkg::*;

    localparam int KEY_W    = DEF_KEY_WIDTH;
    localparam int DEPTH    = DEF_TABLE_DEPTH;
    localparam int S_DATA_W = ((2*KEY_W + VALUE_W + 7)/8)*8;
    localparam int M_DATA_W = ((2*KEY_W + VALUE_W + SLOT_OUT_W + 7)/8)*8;

    // The action field is two bits wide, so the fourth code exists on the wire.
    // The block must treat it as a no-op that answers "not found".
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Cycles without any handshake before the run is declared hung. The worst legal
    // stretch is the long receiver hold-off plus one item of processing.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int POOL_SIZE      = 12;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    m;
        logic [KEY_W-1:0]    n;
        logic [VALUE_W-1:0]  value;
    } table_request_t;

    typedef struct {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [KEY_W-1:0]      fm;
        logic [KEY_W-1:0]      fn;
        logic [VALUE_W-1:0]    fv;
    } table_answer_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata, low bit up: key_m, key_n, new_value, zero fill
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    // s_tuser: action
    logic [ACTION_W-1:0]   s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata, low bit up: slot_index, found_m, found_n, found_value, zero fill
    logic [M_DATA_W-1:0]   m_tdata;
    // m_tuser: status
    logic [STATUS_W-1:0]   m_tuser;

    direct_mapped_pair_key_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Requests waiting to be offered, and answers the table owes us in order.
    table_request_t pending_requests[$];
    table_answer_t  expected_answers[$];

    // Our own copy of the table and of the size register. The key and value arrays
    // start unknown here, but they are only read behind a set valid bit.
    bit                 slot_used [DEPTH];
    logic [KEY_W-1:0]   slot_m    [DEPTH];
    logic [KEY_W-1:0]   slot_n    [DEPTH];
    logic [VALUE_W-1:0] slot_val  [DEPTH];
    logic [SIZE_W-1:0]  table_size_reg = SIZE_RESET;

    // Keys reused across a phase so that lookups and deletes actually hit.
    logic [KEY_W-1:0]   pool_m [POOL_SIZE];
    logic [KEY_W-1:0]   pool_n [POOL_SIZE];

    table_request_t cur_request;
    int  items_accepted = 0;
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  quiet_cycles   = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;

    // A stretch of the run in which neither side stalls at random.
    wire calm = (items_accepted >= 500) && (items_accepted < 750);

    task automatic note_mismatch(input string text);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", text);
    endtask

    // Applies one request to the shadow table and returns the answer the block owes.
    // The slot is the Cantor pairing value s*(s+1)/2 + n, s = m + n, taken exactly
    // in 64 bits and reduced by the clamped table size.
    function automatic table_answer_t table_apply(input table_request_t req);
        longint unsigned sum_mn;
        longint unsigned pair_code;
        longint unsigned modulus;
        int unsigned     slot;
        bit              hit;
        table_answer_t   ans;
        sum_mn    = longint'(req.m) + longint'(req.n);
        pair_code = sum_mn * (sum_mn + 1) / 2 + longint'(req.n);
        if (table_size_reg == 0)
            modulus = 1;
        else if (table_size_reg > DEPTH)
            modulus = DEPTH;
        else
            modulus = 64'(table_size_reg);
        slot = 32'(pair_code % modulus);
        hit  = slot_used[slot] && slot_m[slot] == req.m && slot_n[slot] == req.n;
        ans.status = STAT_NOT_FOUND;
        ans.slot   = slot[SLOT_OUT_W-1:0];
        ans.fm     = '0;
        ans.fn     = '0;
        ans.fv     = '0;
        case (req.action)
            ACT_INSERT:
            begin
                // An insert never reports the stored entry, hit or not.
                if (slot_used[slot])
                    ans.status = STAT_OCCUPIED;
                else
                begin
                    slot_used[slot] = 1'b1;
                    slot_m[slot]    = req.m;
                    slot_n[slot]    = req.n;
                    slot_val[slot]  = req.value;
                    ans.status      = STAT_OK;
                end
            end
            ACT_LOOKUP, ACT_DELETE:
            begin
                if (hit)
                begin
                    ans.status = STAT_OK;
                    ans.fm     = slot_m[slot];
                    ans.fn     = slot_n[slot];
                    ans.fv     = slot_val[slot];
                    if (req.action == ACT_DELETE)
                        slot_used[slot] = 1'b0;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic queue_item(input logic [ACTION_W-1:0] action, input logic [KEY_W-1:0] m,
                              input logic [KEY_W-1:0] n, input logic [VALUE_W-1:0] value);
        table_request_t req;
        req.action = action;
        req.m      = m;
        req.n      = n;
        req.value  = value;
        pending_requests.push_back(req);
    endtask

    // Fresh keys for a phase: tiny ones, full-range ones and the corners.
    task automatic refill_key_pool();
        int kind;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            kind = $urandom_range(3);
            case (kind)
                0:
                begin
                    pool_m[i] = KEY_W'($urandom_range(7));
                    pool_n[i] = KEY_W'($urandom_range(7));
                end
                1:
                begin
                    pool_m[i] = $urandom_range(1) ? '1 : '0;
                    pool_n[i] = $urandom_range(1) ? '1 : KEY_W'($urandom);
                end
                default:
                begin
                    pool_m[i] = KEY_W'($urandom);
                    pool_n[i] = KEY_W'($urandom);
                end
            endcase
        end
    endtask

    // Mostly well-formed traffic on the pool keys; the rest is random keys and
    // the unused action code.
    task automatic queue_random(input int count);
        int             pick;
        int             k;
        table_request_t req;
        for (int i = 0; i < count; i++)
        begin
            k    = $urandom_range(POOL_SIZE - 1);
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                req.m = pool_m[k];
                req.n = pool_n[k];
            end
            else
            begin
                req.m = KEY_W'($urandom);
                req.n = KEY_W'($urandom);
            end
            pick = $urandom_range(99);
            if (pick < 38)
                req.action = ACT_INSERT;
            else if (pick < 70)
                req.action = ACT_LOOKUP;
            else if (pick < 96)
                req.action = ACT_DELETE;
            else
                req.action = ACT_UNUSED;
            req.value = VALUE_W'($urandom);
            pending_requests.push_back(req);
        end
    endtask

    // Waits at falling edges until every request went out and every answer came back.
    // Every word gives a result, so an empty answer queue means the block is idle.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_answers.size() != 0);
    endtask

    // Writes table_size through the APB port and reads it back. The write lands at
    // the access edge; the read starts right after as a back-to-back transfer.
    task automatic write_table_size(input logic [SIZE_W-1:0] size);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TABLE_SIZE;
        pwdata  <= APB_DW'(size);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        table_size_reg = size;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== APB_DW'(size))
            note_mismatch($sformatf("table_size read back %0h, expected %0h", prdata, size));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stimulus: directed corners at the reset size, then random phases at a range
    // of sizes including zero and values past the table depth.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table, then the extreme keys and values, a collision in slot zero
        // ((5,0) pairs to 15, which folds onto (0,0) at size 15), a key mismatch on
        // an occupied slot, a double delete and the unused action.
        queue_item(ACT_LOOKUP, 16'h0000, 16'h0000, 31'h0);
        queue_item(ACT_INSERT, 16'h0000, 16'h0000, 31'h7fffffff);
        queue_item(ACT_LOOKUP, 16'h0000, 16'h0000, 31'h0);
        queue_item(ACT_INSERT, 16'h0000, 16'h0000, 31'h1234567);
        queue_item(ACT_INSERT, 16'hffff, 16'hffff, 31'h0);
        queue_item(ACT_LOOKUP, 16'hffff, 16'hffff, 31'h7fffffff);
        queue_item(ACT_LOOKUP, 16'hffff, 16'h0000, 31'h0);
        queue_item(ACT_DELETE, 16'hffff, 16'hffff, 31'h0);
        queue_item(ACT_DELETE, 16'hffff, 16'hffff, 31'h0);
        queue_item(ACT_UNUSED, 16'hffff, 16'hffff, 31'h7fffffff);
        queue_item(ACT_UNUSED, 16'h0000, 16'h0000, 31'h0);
        queue_item(ACT_LOOKUP, 16'h0000, 16'h0000, 31'h0);
        queue_item(ACT_DELETE, 16'h0005, 16'h0000, 31'h0);
        queue_item(ACT_INSERT, 16'h0005, 16'h0000, 31'h0);
        queue_item(ACT_DELETE, 16'h0000, 16'h0000, 31'h0);
        queue_item(ACT_INSERT, 16'h0005, 16'h0000, 31'h2aaaaaaa);
        queue_item(ACT_LOOKUP, 16'h0000, 16'h0000, 31'h0);
        queue_item(ACT_LOOKUP, 16'h0005, 16'h0000, 31'h0);
        queue_item(ACT_INSERT, 16'h8000, 16'h7fff, 31'h55555555);
        queue_item(ACT_LOOKUP, 16'h8000, 16'h7fff, 31'h0);
        drain();

        refill_key_pool();
        queue_random(250);
        drain();

        // Smallest and largest legal sizes, then zero and sizes past the depth,
        // which the block must clamp.
        write_table_size(5'd1);
        refill_key_pool();
        queue_random(100);
        drain();

        write_table_size(5'd16);
        refill_key_pool();
        queue_random(300);
        drain();

        write_table_size(5'd0);
        refill_key_pool();
        queue_random(80);
        drain();

        write_table_size(5'd31);
        refill_key_pool();
        queue_random(150);
        drain();

        write_table_size(5'd17);
        refill_key_pool();
        queue_random(60);
        drain();

        write_table_size(5'd2);
        refill_key_pool();
        queue_random(150);
        drain();

        repeat (4)
        begin
            write_table_size(SIZE_W'($urandom_range(31)));
            refill_key_pool();
            queue_random(90);
            drain();
        end

        // Let any stray word show up before the verdict.
        repeat (100) @(posedge clk);
        if (expected_answers.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
        if (mismatches == 0)
            $display("[direct_mapped_pair_key_table] OK");
        else
            $display("[direct_mapped_pair_key_table] ERROR");
        $finish;
    end

    // Request driver. A word stays on the bus until taken; the prediction is made
    // at the edge where it is taken, so the shadow table follows the block's order.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_answers.push_back(table_apply(cur_request));
                items_accepted <= items_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 8))
                begin
                    cur_request = pending_requests.pop_front();
                    s_tdata  <= S_DATA_W'({cur_request.value, cur_request.n, cur_request.m});
                    s_tuser  <= cur_request.action;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver. Besides the random stalls it holds off once for a long
    // stretch while the driver keeps offering, so the output register fills and
    // the block has to stall its input.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && results_seen >= 400)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 8);
    end

    // Result monitor: every word taken is checked field by field against the
    // oldest answer we predicted.
    always @(posedge clk)
    begin
        table_answer_t got;
        table_answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = status_t'(m_tuser);
            got.slot   = m_tdata[SLOT_OUT_W-1:0];
            got.fm     = m_tdata[SLOT_OUT_W +: KEY_W];
            got.fn     = m_tdata[SLOT_OUT_W+KEY_W +: KEY_W];
            got.fv     = m_tdata[SLOT_OUT_W+2*KEY_W +: VALUE_W];
            results_seen <= results_seen + 1;
            if (expected_answers.size() == 0)
                note_mismatch($sformatf("unexpected result: status %0d slot %0d m %0h n %0h v %0h",
                    got.status, got.slot, got.fm, got.fn, got.fv));
            else
            begin
                want = expected_answers.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.fm !== want.fm || got.fn !== want.fn || got.fv !== want.fv)
                    note_mismatch($sformatf(
                        "result %0d: expected status %0d slot %0d m %0h n %0h v %0h, got status %0d slot %0d m %0h n %0h v %0h",
                        results_seen, want.status, want.slot, want.fm, want.fn, want.fv,
                        got.status, got.slot, got.fm, got.fn, got.fv));
            end
        end
    end

    // Watchdog: any word moving on either stream, or a configuration transfer,
    // counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[direct_mapped_pair_key_table] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dmpk_pkg.sv
rtl/dmpk_divstep.sv
rtl/dmpk_mem.sv
rtl/dmpk_seq.sv
rtl/direct_mapped_pair_key_table.sv
bench/tb_direct_mapped_pair_key_table.sv
